// ----- design/pol_pkg.sv -----
package pol_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int CMD_W = 3;
  localparam int POS_W = 7;
  localparam int VAL_W = 32;
  localparam int ST_W  = 3;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 56;
  localparam int OUT_PAD_W  = OUT_DATA_W - (ST_W + POS_W + VAL_W + POS_W);

  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [ST_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic                    valid;
    logic [ST_W-1:0]         status;
    logic [POS_W-1:0]        found_position;
    logic signed [VAL_W-1:0] element;
    logic [POS_W-1:0]        list_length;
    logic                    last;
  } pol_emit_t;

endpackage

// ----- design/positional_ordered_list.sv -----
// channel   | signals              | item
// ----------+----------------------+-------------------------------------------
// command   | s_axis_* tdata/tuser | tuser: command; tdata: position, value
// result    | m_axis_* tdata/tlast | tdata: status, found_position, element,
//           |                      | list_length; tlast: last
//
// one command at a time; s_axis_tready is high only while idle
// append and errors: decode, then emit; insert/delete: read and rewrite each
// moved element; search: count the matches in one pass, then report each in
// a second; read-out: read, emit each element; all through the single memory
// read port; a stalled result holds the sequencer; reset empties the list
module positional_ordered_list #(
  parameter int DEPTH = pol_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [pol_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // position, value
  input  logic [pol_pkg::CMD_W-1:0]      s_axis_tuser,   // command
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [pol_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // status, found_position,
                                                          // element, list_length
  output logic                           m_axis_tlast
);
  import pol_pkg::*;

  localparam int AW = $clog2(DEPTH);

  pol_emit_t         emit;
  logic              out_free;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [VAL_W-1:0]  wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [VAL_W-1:0]  rd_data;

  logic [ST_W-1:0]   out_status;
  logic [POS_W-1:0]  out_fpos;
  logic [VAL_W-1:0]  out_elem;
  logic [POS_W-1:0]  out_len;
  logic              out_last;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  pol_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_command  (s_axis_tuser),
    .in_position (s_axis_tdata[POS_W-1:0]),
    .in_value    (s_axis_tdata[POS_W+VAL_W-1:POS_W]),
    .out_free    (out_free),
    .emit        (emit),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  pol_mem #(.DEPTH(DEPTH)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit.valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_status <= emit.status;
      out_fpos   <= emit.found_position;
      out_elem   <= emit.element;
      out_len    <= emit.list_length;
      out_last   <= emit.last;
    end
  end

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_len, out_elem, out_fpos, out_status};
  assign m_axis_tlast = out_last;

  a_len_bound : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_len <= POS_W'(DEPTH)))
    else $error("list length above depth");

  a_err_last : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_status != ST_OK) |-> out_last)
    else $error("error status on a non-final item");

  a_pos_bound : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_fpos <= out_len))
    else $error("reported position beyond list length");

  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !emit.valid)
    else $error("result register overwritten while stalled");

endmodule

// ----- design/pol_mem.sv -----
module pol_mem #(
  parameter int DEPTH = pol_pkg::DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [pol_pkg::VAL_W-1:0]  wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [pol_pkg::VAL_W-1:0]  rd_data
);
  import pol_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/pol_ctrl.sv -----
module pol_ctrl #(
  parameter int DEPTH = pol_pkg::DEPTH_DEF,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [pol_pkg::CMD_W-1:0]  in_command,
  input  logic [pol_pkg::POS_W-1:0]  in_position,
  input  logic [pol_pkg::VAL_W-1:0]  in_value,
  input  logic                       out_free,
  output pol_pkg::pol_emit_t         emit,
  output logic                       wr_en,
  output logic [AW-1:0]              wr_addr,
  output logic [pol_pkg::VAL_W-1:0]  wr_data,
  output logic                       rd_en,
  output logic [AW-1:0]              rd_addr,
  input  logic [pol_pkg::VAL_W-1:0]  rd_data
);
  import pol_pkg::*;

  typedef enum logic [3:0] {
    IDLE, DECODE, SHIFT_RD, SHIFT_WR, CNT_RD, CNT_CHK, SCAN_RD, SCAN_CHK, EMIT
  } state_t;

  state_t            state;
  logic [CMD_W-1:0]  cmd;
  logic [POS_W-1:0]  pos;
  logic [VAL_W-1:0]  val;
  logic [CW-1:0]     len;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     hits;
  logic [CW-1:0]     seen;
  logic [ST_W-1:0]   res_status;
  logic [POS_W-1:0]  res_fpos;
  logic [VAL_W-1:0]  res_elem;
  logic              res_last;

  logic [POS_W-1:0]  len_p;
  logic [POS_W-1:0]  idx_p;
  logic [POS_W-1:0]  pos_m1;
  logic [POS_W:0]    len_inc;
  logic [CW-1:0]     idx_inc;
  logic [CW-1:0]     idx_dec;
  logic              full;
  logic              empty;
  logic              ins_ok;
  logic              del_ok;
  logic              hit;

  assign len_p   = POS_W'(len);
  assign idx_p   = POS_W'(idx);
  assign pos_m1  = pos - POS_W'(1);
  assign len_inc = {1'b0, len_p} + (POS_W + 1)'(1);
  assign idx_inc = idx + CW'(1);
  assign idx_dec = idx - CW'(1);
  assign full    = (len == CW'(DEPTH));
  assign empty   = (len == '0);
  assign ins_ok  = (pos != '0) && ({1'b0, pos} <= len_inc);
  assign del_ok  = (pos != '0) && (pos <= len_p);
  // shared compare unit
  assign hit     = (rd_data == val);

  assign in_ready = (state == IDLE);

  assign emit.valid          = (state == EMIT) && out_free;
  assign emit.status         = res_status;
  assign emit.found_position = res_fpos;
  assign emit.element        = res_elem;
  assign emit.list_length    = len_p;
  assign emit.last           = res_last;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = len[AW-1:0];
    wr_data = val;
    rd_en   = 1'b0;
    rd_addr = idx[AW-1:0];
    case (state)
      DECODE: begin
        wr_en = (cmd == CMD_APPEND) && !full;
      end
      SHIFT_RD: begin
        if (cmd == CMD_INSERT) begin
          if (idx_p >= pos) begin
            rd_en   = 1'b1;
            rd_addr = idx_dec[AW-1:0];
          end else begin
            wr_en   = 1'b1;
            wr_addr = pos_m1[AW-1:0];
          end
        end else if (idx_inc < len) begin
          rd_en   = 1'b1;
          rd_addr = idx_inc[AW-1:0];
        end
      end
      SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx[AW-1:0];
        wr_data = rd_data;
      end
      CNT_RD: begin
        rd_en = (idx < len);
      end
      SCAN_RD: begin
        rd_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      len   <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid) begin
            cmd   <= in_command;
            pos   <= in_position;
            val   <= in_value;
            state <= DECODE;
          end
        end
        DECODE: begin
          res_fpos <= '0;
          res_elem <= '0;
          res_last <= 1'b1;
          case (cmd)
            CMD_APPEND: begin
              if (full) begin
                res_status <= ST_FULL;
              end else begin
                res_status <= ST_OK;
                len        <= len + CW'(1);
              end
              state <= EMIT;
            end
            CMD_INSERT: begin
              if (full) begin
                res_status <= ST_FULL;
                state      <= EMIT;
              end else if (!ins_ok) begin
                res_status <= ST_BADPOS;
                state      <= EMIT;
              end else begin
                idx   <= len;
                state <= SHIFT_RD;
              end
            end
            CMD_DELETE: begin
              if (empty) begin
                res_status <= ST_EMPTY;
                state      <= EMIT;
              end else if (!del_ok) begin
                res_status <= ST_BADPOS;
                state      <= EMIT;
              end else begin
                idx   <= pos_m1[CW-1:0];
                state <= SHIFT_RD;
              end
            end
            CMD_SEARCH: begin
              if (empty) begin
                res_status <= ST_NOTFOUND;
                state      <= EMIT;
              end else begin
                idx   <= '0;
                hits  <= '0;
                state <= CNT_RD;
              end
            end
            CMD_READ: begin
              res_status <= ST_OK;
              if (empty) begin
                state <= EMIT;
              end else begin
                idx   <= '0;
                state <= SCAN_RD;
              end
            end
            default: begin
              state <= IDLE;
            end
          endcase
        end
        SHIFT_RD: begin
          if (cmd == CMD_INSERT) begin
            if (idx_p >= pos) begin
              state <= SHIFT_WR;
            end else begin
              len        <= len + CW'(1);
              res_status <= ST_OK;
              state      <= EMIT;
            end
          end else if (idx_inc < len) begin
            state <= SHIFT_WR;
          end else begin
            len        <= len - CW'(1);
            res_status <= ST_OK;
            state      <= EMIT;
          end
        end
        SHIFT_WR: begin
          idx   <= (cmd == CMD_INSERT) ? idx_dec : idx_inc;
          state <= SHIFT_RD;
        end
        CNT_RD: begin
          if (idx < len) begin
            state <= CNT_CHK;
          end else if (hits == '0) begin
            res_status <= ST_NOTFOUND;
            state      <= EMIT;
          end else begin
            idx   <= '0;
            seen  <= '0;
            state <= SCAN_RD;
          end
        end
        CNT_CHK: begin
          if (hit) begin
            hits <= hits + CW'(1);
          end
          idx   <= idx_inc;
          state <= CNT_RD;
        end
        SCAN_RD: begin
          state <= SCAN_CHK;
        end
        SCAN_CHK: begin
          res_status <= ST_OK;
          res_fpos   <= idx_p + POS_W'(1);
          if (cmd == CMD_READ) begin
            res_elem <= rd_data;
            res_last <= (idx_inc == len);
            state    <= EMIT;
          end else if (hit) begin
            res_elem <= '0;
            res_last <= ((seen + CW'(1)) == hits);
            seen     <= seen + CW'(1);
            state    <= EMIT;
          end else begin
            idx   <= idx_inc;
            state <= SCAN_RD;
          end
        end
        EMIT: begin
          if (out_free) begin
            if (res_last) begin
              state <= IDLE;
            end else begin
              idx   <= idx_inc;
              state <= SCAN_RD;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import pol_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;
  localparam int MAX_REPORTS = 30;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [POS_W-1:0] found_position;
    logic [VAL_W-1:0] element;
    logic [POS_W-1:0] list_length;
    logic             last;
  } list_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [CMD_W-1:0]      s_axis_tuser = CMD_APPEND;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  // mirror of the list contents
  logic [VAL_W-1:0] list_model [DEPTH];
  int               list_len = 0;
  list_result_t     awaited_results [$];

  int send_idle_pct = 37;
  int recv_idle_pct = 46;
  int fail_count = 0;

  positional_ordered_list uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("[positional_ordered_list] ERROR");
    $finish;
  end

  function automatic void queue_result(logic [ST_W-1:0] status, int fpos,
                                       logic [VAL_W-1:0] elem, bit last);
    list_result_t r;
    r.status         = status;
    r.found_position = POS_W'(fpos);
    r.element        = elem;
    r.list_length    = POS_W'(list_len);
    r.last           = last;
    awaited_results.push_back(r);
  endfunction

  function automatic void apply_list_command(logic [CMD_W-1:0] cmd,
                                             logic [POS_W-1:0] pos,
                                             logic [VAL_W-1:0] val);
    int p;
    int hits;
    int seen;
    p = int'(pos);
    hits = 0;
    seen = 0;
    case (cmd)
      CMD_APPEND: begin
        if (list_len >= DEPTH) begin
          queue_result(ST_FULL, 0, '0, 1'b1);
        end else begin
          list_model[list_len] = val;
          list_len++;
          queue_result(ST_OK, 0, '0, 1'b1);
        end
      end
      CMD_INSERT: begin
        if (list_len >= DEPTH) begin
          queue_result(ST_FULL, 0, '0, 1'b1);
        end else if (p < 1 || p > list_len + 1) begin
          queue_result(ST_BADPOS, 0, '0, 1'b1);
        end else begin
          for (int i = list_len; i >= p; i--) list_model[i] = list_model[i-1];
          list_model[p-1] = val;
          list_len++;
          queue_result(ST_OK, 0, '0, 1'b1);
        end
      end
      CMD_DELETE: begin
        if (list_len == 0) begin
          queue_result(ST_EMPTY, 0, '0, 1'b1);
        end else if (p < 1 || p > list_len) begin
          queue_result(ST_BADPOS, 0, '0, 1'b1);
        end else begin
          for (int i = p - 1; i + 1 < list_len; i++) list_model[i] = list_model[i+1];
          list_len--;
          queue_result(ST_OK, 0, '0, 1'b1);
        end
      end
      CMD_SEARCH: begin
        for (int i = 0; i < list_len; i++) if (list_model[i] == val) hits++;
        if (hits == 0) begin
          queue_result(ST_NOTFOUND, 0, '0, 1'b1);
        end else begin
          for (int i = 0; i < list_len; i++) begin
            if (list_model[i] == val) begin
              seen++;
              queue_result(ST_OK, i + 1, '0, seen == hits);
            end
          end
        end
      end
      CMD_READ: begin
        if (list_len == 0) begin
          queue_result(ST_OK, 0, '0, 1'b1);
        end else begin
          for (int i = 0; i < list_len; i++)
            queue_result(ST_OK, i + 1, list_model[i], i + 1 == list_len);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                           logic [VAL_W-1:0] val);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {{(IN_DATA_W - VAL_W - POS_W){1'b0}}, val, pos};
    do @(posedge clk); while (!s_axis_tready);
    apply_list_command(cmd, pos, val);
  endtask

  function automatic void flag_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      if (fail_count < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    list_result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status         = m_axis_tdata[0 +: ST_W];
      got.found_position = m_axis_tdata[ST_W +: POS_W];
      got.element        = m_axis_tdata[ST_W + POS_W +: VAL_W];
      got.list_length    = m_axis_tdata[ST_W + POS_W + VAL_W +: POS_W];
      got.last           = m_axis_tlast;
      if (awaited_results.size() == 0) begin
        if (fail_count < MAX_REPORTS)
          $display("%0t: unexpected item, expected none, actual %0h", $time, got);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        flag_field("status", 32'(want.status), 32'(got.status));
        flag_field("found_position", 32'(want.found_position), 32'(got.found_position));
        flag_field("element", want.element, got.element);
        flag_field("list_length", 32'(want.list_length), 32'(got.list_length));
        flag_field("last", 32'(want.last), 32'(got.last));
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic test_empty_list();
    send_item(CMD_READ, 7'd0, '0);
    send_item(CMD_SEARCH, 7'd0, '0);
    send_item(CMD_DELETE, 7'd1, '0);
    send_item(CMD_INSERT, 7'd2, 32'd9);
    send_item(CMD_RSVD7, 7'd1, 32'hffff_ffff);
  endtask

  task automatic test_fill_and_overflow();
    send_item(CMD_APPEND, 7'd0, 32'h8000_0000);
    send_item(CMD_APPEND, 7'h7f, 32'h7fff_ffff);
    send_item(CMD_INSERT, 7'd1, 32'd7);
    send_item(CMD_INSERT, 7'd4, 32'd7);
    for (int i = 0; i < DEPTH - 4; i++)
      send_item(CMD_APPEND, 7'd0, (i % 3 == 0) ? 32'd7 : 32'($urandom));
    send_item(CMD_APPEND, 7'd0, 32'd1);
    send_item(CMD_INSERT, 7'd1, 32'd1);
    send_item(CMD_READ, 7'd0, '0);
  endtask

  task automatic test_edit_bounds();
    send_item(CMD_SEARCH, 7'd0, 32'd7);
    send_item(CMD_DELETE, 7'h7f, '0);
    send_item(CMD_DELETE, 7'(DEPTH), '0);
  endtask

  task automatic random_item(output bit counted);
    int r;
    int hi;
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    r = $urandom_range(99);
    // lean towards deletes as the list fills, so both ends are reached
    if (r < 6) cmd = CMD_RSVD5 + CMD_W'($urandom_range(2));
    else if (r < 16) cmd = CMD_READ;
    else if (r < 30) cmd = CMD_SEARCH;
    else if (r < 80 - 2 * list_len) cmd = $urandom_range(1) ? CMD_INSERT : CMD_APPEND;
    else cmd = CMD_DELETE;
    hi = (cmd == CMD_DELETE) ? ((list_len > 0) ? list_len : 1) : list_len + 1;
    r = $urandom_range(9);
    if (r == 0) pos = POS_W'($urandom);
    else if (r == 1) pos = POS_W'(hi + 1);
    else pos = POS_W'($urandom_range(1, hi));
    r = $urandom_range(9);
    if (cmd == CMD_SEARCH && list_len > 0 && r < 6) begin
      val = list_model[$urandom_range(list_len - 1)];
    end else if (r < 4) begin
      case ($urandom_range(3))
        0: val = 32'h0;
        1: val = 32'h7fff_ffff;
        2: val = 32'h8000_0000;
        default: val = 32'd7;
      endcase
    end else begin
      val = $urandom;
    end
    send_item(cmd, pos, val);
    counted = (cmd <= CMD_READ);
  endtask

  task automatic test_random_traffic(int n);
    int done;
    bit counted;
    done = 0;
    while (done < n) begin
      random_item(counted);
      if (counted) done++;
    end
  endtask

  initial begin
    int guard;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_fill_and_overflow();
    test_edit_bounds();
    test_random_traffic(45);
    send_idle_pct = 46;
    recv_idle_pct = 37;
    test_random_traffic(45);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(44);
    s_axis_tvalid <= 1'b0;
    guard = 0;
    while (awaited_results.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $display("%0t: results missing, expected %0d more, actual 0", $time,
               awaited_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("[positional_ordered_list] OK");
    end else begin
      $display("[positional_ordered_list] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/pol_pkg.sv
design/pol_mem.sv
design/pol_ctrl.sv
design/positional_ordered_list.sv
dv/tb_top.sv
